// ===== design/hipt_pkg.sv =====
// Shared constants and types of the hashed inverted page table.
package hipt_pkg;

    localparam int NUM_BUCKETS  = 16;
    localparam int BUCKET_DEPTH = 4;

    localparam int PID_W   = 10;
    localparam int PAGE_W  = 20;
    localparam int KEY_W   = PID_W + PAGE_W;
    localparam int CNT_W   = 5;
    localparam int BKT_W   = $clog2(NUM_BUCKETS);
    localparam int SLOT_W  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
    localparam int ADDR_W  = BKT_W + SLOT_W;
    localparam int STORE_DEPTH = NUM_BUCKETS * BUCKET_DEPTH;

    // Remainder unit: the hash sum is reduced a fixed number of bits per cycle.
    localparam int MOD_STEP_BITS = 7;
    localparam int MOD_STEPS     = 3;
    localparam int SUM_W         = MOD_STEP_BITS * MOD_STEPS;
    localparam int MOD_STEP_W    = $clog2(MOD_STEPS);

    localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = CNT_W'(NUM_BUCKETS);

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } operation_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_HASH,
        S_SCAN,
        S_RESULT
    } state_t;

endpackage

// ===== design/hipt_mod.sv =====
// Iterative remainder unit: dividend modulo a small divisor, several bits per cycle.
module hipt_mod
    import hipt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [BKT_W-1:0] remainder
);

    logic [SUM_W-1:0]      shift_reg;
    logic [BKT_W-1:0]      rem_reg;
    logic [BKT_W-1:0]      rem_next;
    logic [CNT_W-1:0]      divisor_reg;
    logic [MOD_STEP_W-1:0] step_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic                  last_step;

    assign last_step = (step_reg == MOD_STEP_W'(MOD_STEPS - 1));

    // Shift in one dividend bit at a time, subtract the divisor once when it fits
    always_comb
    begin
        logic [BKT_W-1:0] r;
        logic [BKT_W:0]   t;
        r = rem_reg;
        t = '0;
        for (int k = 0; k < MOD_STEP_BITS; k++)
        begin
            t = {r, shift_reg[SUM_W-1-k]};
            if (t >= divisor_reg)
            begin
                t = t - divisor_reg;
            end
            r = t[BKT_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
                step_reg <= step_reg + MOD_STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg   <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << MOD_STEP_BITS;
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, rem_reg} < divisor_reg))
        else $error("remainder not below divisor");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("remainder unit did not start");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (divisor_reg != '0))
        else $error("zero divisor in remainder unit");

endmodule

// ===== design/hashed_inverted_page_table.sv =====
// Hashed inverted page table: insert or look up (process id, page) pairs in fixed buckets.
// Each request hashes (process_id + page_number) modulo the bucket count in use, then
// either appends the pair to that bucket (or reports it full) or scans it in insertion order.
// An insert passes through the remainder unit (7 bits of the 21-bit sum per cycle), one
// handoff, the bucket update and the load of the result register. A search also passes
// the remainder unit, then reads and compares the filled slots of its bucket (up to 4)
// in turn, since the entry memory has one read port, and stops at the first match; a
// search that finds nothing reads every filled slot of its bucket. A new request is
// taken while a result still waits at the output.
// Fill counts are cleared by reset; the entry memory needs no clearing.
module hashed_inverted_page_table
    import hipt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [PID_W-1:0]  process_id,
    input  logic [PAGE_W-1:0] page_number,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [BKT_W-1:0]  bucket_index,
    output logic [SLOT_W-1:0] slot_index,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata
);

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  bucket_count_reg;
    logic [CNT_W-1:0]  buckets_used;

    operation_t        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [BKT_W-1:0]  bucket_reg;
    logic [BKT_W-1:0]  bucket_next;
    logic [FILL_W-1:0] cur_fill_reg;
    logic [FILL_W-1:0] cur_fill_next;
    logic [FILL_W-1:0] issue_slot_reg;
    logic [FILL_W-1:0] issue_slot_next;
    logic              pend_reg;
    logic              pend_next;
    logic [SLOT_W-1:0] pend_slot_reg;
    logic [SLOT_W-1:0] pend_slot_next;
    status_t           res_status_reg;
    status_t           res_status_next;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [SLOT_W-1:0] res_slot_next;

    logic [FILL_W-1:0] bucket_fill_reg [NUM_BUCKETS];
    logic              fill_we;
    logic [BKT_W-1:0]  fill_waddr;
    logic [FILL_W-1:0] fill_wdata;
    logic [FILL_W-1:0] hit_fill;

    logic [KEY_W-1:0]  entry_mem [STORE_DEPTH];
    logic [KEY_W-1:0]  mem_rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [BKT_W-1:0]  out_bucket_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_load;

    logic              in_xfer;
    logic              mod_done;
    logic [BKT_W-1:0]  mod_rem;
    logic              key_match;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;

    // Zero acts as one bucket, anything above the table size as the full table
    always_comb
    begin
        if (bucket_count_reg == '0)
        begin
            buckets_used = CNT_W'(1);
        end
        else if (bucket_count_reg > CNT_W'(NUM_BUCKETS))
        begin
            buckets_used = CNT_W'(NUM_BUCKETS);
        end
        else
        begin
            buckets_used = bucket_count_reg;
        end
    end

    hipt_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_xfer),
        .dividend  (SUM_W'(process_id) + SUM_W'(page_number)),
        .divisor   (buckets_used),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign hit_fill  = bucket_fill_reg[mod_rem];
    assign key_match = pend_reg && (mem_rdata_reg == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        bucket_next     = bucket_reg;
        cur_fill_next   = cur_fill_reg;
        issue_slot_next = issue_slot_reg;
        pend_next       = pend_reg;
        pend_slot_next  = pend_slot_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        fill_we         = 1'b0;
        fill_waddr      = mod_rem;
        fill_wdata      = hit_fill + FILL_W'(1);
        mem_we          = 1'b0;
        mem_waddr       = {mod_rem, hit_fill[SLOT_W-1:0]};
        mem_re          = 1'b0;
        mem_raddr       = {bucket_reg, issue_slot_reg[SLOT_W-1:0]};
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (mod_done)
                begin
                    bucket_next     = mod_rem;
                    cur_fill_next   = hit_fill;
                    issue_slot_next = '0;
                    pend_next       = 1'b0;
                    res_slot_next   = '0;
                    if (op_reg == OP_SEARCH)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (hit_fill >= FILL_W'(BUCKET_DEPTH))
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        fill_we         = 1'b1;
                        res_status_next = ST_INSERTED;
                        res_slot_next   = hit_fill[SLOT_W-1:0];
                        state_next      = S_RESULT;
                    end
                end
            end
            S_SCAN:
            begin
                // Compare the slot read last cycle while the next slot is fetched
                priority if (key_match)
                begin
                    res_status_next = ST_FOUND;
                    res_slot_next   = pend_slot_reg;
                    pend_next       = 1'b0;
                    state_next      = S_RESULT;
                end
                else if (issue_slot_reg < cur_fill_reg)
                begin
                    mem_re          = 1'b1;
                    pend_next       = 1'b1;
                    pend_slot_next  = issue_slot_reg[SLOT_W-1:0];
                    issue_slot_next = issue_slot_reg + FILL_W'(1);
                end
                else
                begin
                    res_status_next = ST_NOT_FOUND;
                    res_slot_next   = '0;
                    pend_next       = 1'b0;
                    state_next      = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BUCKET_COUNT_RESET;
            pend_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                bucket_fill_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                bucket_count_reg <= cfg_wdata;
            end
            pend_reg <= pend_next;
            if (fill_we)
            begin
                bucket_fill_reg[fill_waddr] <= fill_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg  <= operation_t'(operation);
            key_reg <= {process_id, page_number};
        end
        bucket_reg     <= bucket_next;
        cur_fill_reg   <= cur_fill_next;
        issue_slot_reg <= issue_slot_next;
        pend_slot_reg  <= pend_slot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_bucket_reg <= bucket_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= key_reg;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= entry_mem[mem_raddr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign bucket_index = out_bucket_reg;
    assign slot_index   = out_slot_reg;

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("second request taken while one is in progress");

    a_hash_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == S_HASH))
        else $error("hash finished outside the hash wait");

    a_read_then_compare: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> (state_reg == S_SCAN) && pend_reg)
        else $error("slot read not followed by a compare");

    a_scan_filled_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && pend_reg |-> (FILL_W'(pend_slot_reg) < cur_fill_reg))
        else $error("compare of an unfilled slot");

endmodule
